>>> src/hts_pkg.sv
// shared types and constants for the hysteresis thermostat with setpoint keys
package hts_pkg;

    localparam int unsigned TEMP_W     = 15;
    localparam int unsigned DEG_W      = 7;
    localparam int unsigned BAND_W     = 11;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 56;
    localparam int unsigned M_DATA_W   = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEATER_BAND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 3'd5;

    // reset values
    localparam logic [BAND_W-1:0]     HYSTERESIS_RST  = 11'd200;
    localparam logic [BAND_W-1:0]     HEATER_BAND_RST = 11'd200;
    localparam logic [DEG_W-1:0]      SP_MIN_RST      = 7'd20;
    localparam logic [DEG_W-1:0]      SP_MAX_RST      = 7'd75;
    localparam logic [CNT_W-1:0]      DEBOUNCE_RST    = 4'd10;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 16'd300;
    localparam logic [DEG_W-1:0]      TARGET_RST      = 7'd60;

    localparam logic [15:0] DEG_SCALE = 16'd100;

    typedef struct packed {
        logic [CNT_W-1:0]      press_level;
        logic [INTERVAL_W-1:0] action_interval_ms;
    } btn_cfg_t;

endpackage

>>> src/hts_button.sv
// debounce counter, press state and action timer for one setpoint key
module hts_button (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             level,
    input  logic [hts_pkg::TIME_W-1:0]       now_ms,
    input  hts_pkg::btn_cfg_t                cfg,
    output logic                             act
);

    logic [hts_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       pressed_reg, pressed_next;
    logic [hts_pkg::TIME_W-1:0] last_reg, last_next;
    logic [hts_pkg::TIME_W-1:0] elapsed;
    logic                       interval_ok;

    // wrapping difference since the last accepted step
    assign elapsed     = now_ms - last_reg;
    assign interval_ok = elapsed >= {16'd0, cfg.action_interval_ms};

    always_comb begin
        // low level means the key is held
        if (!level) begin
            cnt_next = (cnt_reg < cfg.press_level) ? cnt_reg + 4'd1 : cnt_reg;
        end else begin
            cnt_next = (cnt_reg != 4'd0) ? cnt_reg - 4'd1 : cnt_reg;
        end
        pressed_next = pressed_reg;
        last_next    = last_reg;
        act          = 1'b0;
        if (cnt_next >= cfg.press_level && !pressed_reg) begin
            pressed_next = 1'b1;
            if (interval_ok) begin
                act       = 1'b1;
                last_next = now_ms;
            end
        end else if (cnt_next == 4'd0 && pressed_reg) begin
            pressed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pressed_reg <= 1'b0;
            last_reg    <= '0;
        end else if (en) begin
            cnt_reg     <= cnt_next;
            pressed_reg <= pressed_next;
            last_reg    <= last_next;
        end
    end

endmodule

>>> src/hysteresis_thermostat_with_setpoint_keys.sv
// thermostat top level: input register, key handling, relay bands, result register
// a beat passes through the input register and then the result register before it shows on m_
// throughput: one beat per cycle while m_tready keeps the result register draining; key state,
// setpoint and relays update in a single pass between the input register and the result register
// reset: synchronous active-low aresetn clears both pipeline stages, key counters and
// relays, sets the setpoint to 60 and loads all config registers with their defaults
module hysteresis_thermostat_with_setpoint_keys (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // up_level[0], down_level[1], now_ms[33:2], temperature[48:34], zero fill above
    input  logic [hts_pkg::S_DATA_W-1:0]         s_tdata,
    // temp_valid[0]
    input  logic                                 s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // hot_fan_on[0], cold_fan_on[1], heater_on[2], setpoint[9:3], zero fill above
    output logic [hts_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    // config registers
    logic [hts_pkg::BAND_W-1:0]     hyst_reg;
    logic [hts_pkg::BAND_W-1:0]     heat_band_reg;
    logic [hts_pkg::DEG_W-1:0]      sp_min_reg;
    logic [hts_pkg::DEG_W-1:0]      sp_max_reg;
    logic [hts_pkg::CNT_W-1:0]      debounce_reg;
    logic [hts_pkg::INTERVAL_W-1:0] interval_reg;
    hts_pkg::btn_cfg_t              btn_cfg;

    // input stage
    logic                           in_valid_reg;
    logic                           up_level_reg;
    logic                           down_level_reg;
    logic [hts_pkg::TIME_W-1:0]     now_ms_reg;
    logic                           temp_valid_reg;
    logic [hts_pkg::TEMP_W-1:0]     temperature_reg;

    // thermostat state
    logic [hts_pkg::DEG_W-1:0]      target_reg, target_next, target_up;
    logic                           hot_reg, hot_next;
    logic                           cold_reg, cold_next;
    logic                           heater_reg, heater_next;

    // result stage
    logic                           m_valid_reg;
    logic [hts_pkg::M_DATA_W-1:0]   m_data_reg;

    logic                           in_beat;
    logic                           advance;
    logic                           up_act, down_act;

    logic [15:0]                    tgt_u;
    logic signed [15:0]             tgt_s, hyst_s, band_s, temp_s;
    logic signed [15:0]             cool_lim, warm_lim, heat_lim;

    assign in_beat  = s_tvalid && s_tready;
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign btn_cfg.press_level        = debounce_reg;
    assign btn_cfg.action_interval_ms = interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hyst_reg      <= hts_pkg::HYSTERESIS_RST;
            heat_band_reg <= hts_pkg::HEATER_BAND_RST;
            sp_min_reg    <= hts_pkg::SP_MIN_RST;
            sp_max_reg    <= hts_pkg::SP_MAX_RST;
            debounce_reg  <= hts_pkg::DEBOUNCE_RST;
            interval_reg  <= hts_pkg::INTERVAL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                hts_pkg::CFG_HYSTERESIS:  hyst_reg      <= cfg_wdata[10:0];
                hts_pkg::CFG_HEATER_BAND: heat_band_reg <= cfg_wdata[10:0];
                hts_pkg::CFG_SP_MIN:      sp_min_reg    <= cfg_wdata[6:0];
                hts_pkg::CFG_SP_MAX:      sp_max_reg    <= cfg_wdata[6:0];
                hts_pkg::CFG_DEBOUNCE:    debounce_reg  <= cfg_wdata[3:0];
                hts_pkg::CFG_INTERVAL:    interval_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_beat) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            up_level_reg    <= s_tdata[0];
            down_level_reg  <= s_tdata[1];
            now_ms_reg      <= s_tdata[33:2];
            temperature_reg <= s_tdata[48:34];
            temp_valid_reg  <= s_tuser;
        end
    end

    hts_button u_up_key (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .level   (up_level_reg),
        .now_ms  (now_ms_reg),
        .cfg     (btn_cfg),
        .act     (up_act)
    );

    hts_button u_down_key (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .level   (down_level_reg),
        .now_ms  (now_ms_reg),
        .cfg     (btn_cfg),
        .act     (down_act)
    );

    // up key is applied before down key
    always_comb begin
        target_up   = (up_act && target_reg < sp_max_reg) ? target_reg + 7'd1 : target_reg;
        target_next = (down_act && target_up > sp_min_reg) ? target_up - 7'd1 : target_up;
    end

    assign tgt_u    = {9'd0, target_next} * hts_pkg::DEG_SCALE;
    assign tgt_s    = $signed(tgt_u);
    assign hyst_s   = $signed({5'd0, hyst_reg});
    assign band_s   = $signed({5'd0, heat_band_reg});
    assign temp_s   = $signed({temperature_reg[14], temperature_reg});
    assign cool_lim = tgt_s - hyst_s;
    assign heat_lim = cool_lim - band_s;
    assign warm_lim = tgt_s + hyst_s;

    always_comb begin
        hot_next    = hot_reg;
        cold_next   = cold_reg;
        heater_next = heater_reg;
        if (temp_valid_reg) begin
            if (temp_s < cool_lim) begin
                hot_next  = 1'b1;
                cold_next = 1'b0;
                // above the heater band the heater holds its state
                if (temp_s < heat_lim) begin
                    heater_next = 1'b1;
                end
            end else if (temp_s > warm_lim) begin
                hot_next    = 1'b0;
                cold_next   = 1'b1;
                heater_next = 1'b0;
            end else begin
                if (!hot_reg && !cold_reg) begin
                    hot_next = 1'b1;
                end
                heater_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= hts_pkg::TARGET_RST;
            hot_reg    <= 1'b0;
            cold_reg   <= 1'b0;
            heater_reg <= 1'b0;
        end else if (advance) begin
            target_reg <= target_next;
            hot_reg    <= hot_next;
            cold_reg   <= cold_next;
            heater_reg <= heater_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {6'd0, target_next, heater_next, cold_next, hot_next};
        end
    end

    a_fans_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(hot_reg && cold_reg))
        else $error("hot and cold fan both on");

    a_heater_with_hot_fan: assert property (@(posedge aclk) disable iff (!aresetn)
        heater_reg |-> hot_reg)
        else $error("heater on without hot fan");

    a_target_moves_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (target_reg != $past(target_reg)) |-> $past(advance))
        else $error("setpoint changed without a beat");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[9:3] == target_reg && m_data_reg[0] == hot_reg))
        else $error("pending result out of step with state");

endmodule

>>> test/testbench.sv
// self-checking testbench for the thermostat: directed and random key and reading beats against a predictor

typedef struct packed {
    logic                up_lvl;
    logic                dn_lvl;
    logic [31:0]         stamp;
    logic                reading;
    logic signed [14:0]  temp;
} key_beat_t;

typedef struct packed {
    logic       hot;
    logic       cold;
    logic       heat;
    logic [6:0] setpoint;
} relay_word_t;

class thermostat_scoreboard;
    logic [hts_pkg::BAND_W-1:0]     hyst;
    logic [hts_pkg::BAND_W-1:0]     band;
    logic [hts_pkg::DEG_W-1:0]      sp_lo;
    logic [hts_pkg::DEG_W-1:0]      sp_hi;
    logic [hts_pkg::DEG_W-1:0]      target;
    logic [hts_pkg::CNT_W-1:0]      db_level;
    logic [hts_pkg::CNT_W-1:0]      up_cnt;
    logic [hts_pkg::CNT_W-1:0]      dn_cnt;
    logic [hts_pkg::INTERVAL_W-1:0] interval;
    logic [hts_pkg::TIME_W-1:0]     up_mark;
    logic [hts_pkg::TIME_W-1:0]     dn_mark;
    logic                           up_held;
    logic                           dn_held;
    logic                           hot;
    logic                           cold;
    logic                           heat;
    relay_word_t                    relay_q[$];
    int                             mismatches;

    function new();
        hyst       = hts_pkg::HYSTERESIS_RST;
        band       = hts_pkg::HEATER_BAND_RST;
        sp_lo      = hts_pkg::SP_MIN_RST;
        sp_hi      = hts_pkg::SP_MAX_RST;
        db_level   = hts_pkg::DEBOUNCE_RST;
        interval   = hts_pkg::INTERVAL_RST;
        target     = hts_pkg::TARGET_RST;
        up_cnt     = '0;
        dn_cnt     = '0;
        up_mark    = '0;
        dn_mark    = '0;
        up_held    = 1'b0;
        dn_held    = 1'b0;
        hot        = 1'b0;
        cold       = 1'b0;
        heat       = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
        case (idx)
            hts_pkg::CFG_HYSTERESIS:  hyst     = value[10:0];
            hts_pkg::CFG_HEATER_BAND: band     = value[10:0];
            hts_pkg::CFG_SP_MIN:      sp_lo    = value[6:0];
            hts_pkg::CFG_SP_MAX:      sp_hi    = value[6:0];
            hts_pkg::CFG_DEBOUNCE:    db_level = value[3:0];
            hts_pkg::CFG_INTERVAL:    interval = value;
            default: ;
        endcase
    endfunction

    function int pending();
        return relay_q.size();
    endfunction

    // saturating counter, press on reaching the level, step only after the interval
    function logic debounce_key(logic level, logic [31:0] now, inout logic [3:0] cnt,
                                inout logic held, inout logic [31:0] mark);
        logic [31:0] elapsed;
        logic        fired;
        fired = 1'b0;
        if (!level) begin
            if (cnt < db_level) cnt = cnt + 4'd1;
        end else if (cnt != 4'd0) begin
            cnt = cnt - 4'd1;
        end
        elapsed = now - mark;
        if (cnt >= db_level && !held) begin
            held = 1'b1;
            if (elapsed >= {16'd0, interval}) begin
                fired = 1'b1;
                mark  = now;
            end
        end else if (cnt == 4'd0 && held) begin
            held = 1'b0;
        end
        return fired;
    endfunction

    function void apply_bands(logic signed [14:0] temp);
        int t;
        int center;
        int lo;
        int hi;
        t      = temp;
        center = int'(target) * 100;
        lo     = center - int'(hyst);
        hi     = center + int'(hyst);
        if (t < lo) begin
            hot  = 1'b1;
            cold = 1'b0;
            // between the two thresholds the heater keeps what it had
            if (t < lo - int'(band)) heat = 1'b1;
        end else if (t > hi) begin
            cold = 1'b1;
            hot  = 1'b0;
            heat = 1'b0;
        end else begin
            if (!hot && !cold) hot = 1'b1;
            heat = 1'b0;
        end
    endfunction

    function void note_beat(key_beat_t b);
        relay_word_t w;
        logic        up_step;
        logic        dn_step;
        up_step = debounce_key(b.up_lvl, b.stamp, up_cnt, up_held, up_mark);
        if (up_step && target < sp_hi) target = target + 7'd1;
        dn_step = debounce_key(b.dn_lvl, b.stamp, dn_cnt, dn_held, dn_mark);
        if (dn_step && target > sp_lo) target = target - 7'd1;
        if (b.reading) apply_bands(b.temp);
        w.hot      = hot;
        w.cold     = cold;
        w.heat     = heat;
        w.setpoint = target;
        relay_q.push_back(w);
    endfunction

    function void check_beat(logic [15:0] data);
        relay_word_t got;
        relay_word_t want;
        got.hot      = data[0];
        got.cold     = data[1];
        got.heat     = data[2];
        got.setpoint = data[9:3];
        if (relay_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result beat %h arrived with nothing expected", data);
            return;
        end
        want = relay_q.pop_front();
        if (got.hot !== want.hot || got.cold !== want.cold || got.heat !== want.heat ||
            got.setpoint !== want.setpoint) begin
            mismatches++;
            if (mismatches <= 10)
                $display("relay beat: expected hot,cold,heater %b%b%b sp %0d, got %b%b%b sp %0d",
                         want.hot, want.cold, want.heat, want.setpoint,
                         got.hot, got.cold, got.heat, got.setpoint);
        end
    endfunction
endclass

module testbench;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 120;

    logic                           aclk;
    logic                           aresetn;
    logic [hts_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           s_tuser;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [hts_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic                           cfg_we;
    logic [hts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hts_pkg::CFG_DATA_W-1:0] cfg_wdata;

    thermostat_scoreboard  sb;
    logic [31:0]           ms_now;
    logic                  steady;
    logic                  long_stall_req;

    hysteresis_thermostat_with_setpoint_keys dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        key_beat_t b;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                b.up_lvl  = s_tdata[0];
                b.dn_lvl  = s_tdata[1];
                b.stamp   = s_tdata[33:2];
                b.temp    = s_tdata[48:34];
                b.reading = s_tuser;
                sb.note_beat(b);
            end
            if (m_tvalid && m_tready) sb.check_beat(m_tdata);
        end
    end

    initial begin : receiver
        int dur;
        int r;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready <= 1'b1;
                    dur = $urandom_range(1, 10);
                end else if (r < 93) begin
                    m_tready <= 1'b0;
                    dur = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    dur = $urandom_range(10, 40);
                end
                repeat (dur - 1) @(negedge aclk);
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("hysteresis_thermostat_with_setpoint_keys: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly near the current bands, some on or just past a threshold, some anywhere
    function automatic logic signed [14:0] pick_temp();
        int center;
        int h;
        int b;
        int spread;
        int r;
        int v;
        center = int'(sb.target) * 100;
        h      = int'(sb.hyst);
        b      = int'(sb.band);
        r      = $urandom_range(0, 99);
        if (r < 3) begin
            v = int'($urandom_range(0, 32767)) - 16384;
        end else if (r < 13) begin
            v = int'($urandom_range(0, 17500)) - 4500;
        end else if (r < 25) begin
            case ($urandom_range(0, 5))
                0: v = center - h;
                1: v = center - h - 1;
                2: v = center + h;
                3: v = center + h + 1;
                4: v = center - h - b;
                default: v = center - h - b - 1;
            endcase
        end else begin
            spread = h + b + 300;
            v = center - spread + int'($urandom_range(0, 2 * spread));
        end
        if (v > 16383) v = 16383;
        if (v < -16384) v = -16384;
        return v[14:0];
    endfunction

    function automatic logic [31:0] next_ms(logic [31:0] t);
        int unsigned iv;
        int unsigned r;
        iv = sb.interval;
        r  = $urandom_range(0, 99);
        if (r < 2) return $urandom();
        if (r < 30) return t + $urandom_range(0, 2 * iv + 10);
        return t + $urandom_range(0, iv / 4 + 20);
    endfunction

    // alternate held and released stretches, mostly long enough to cross the debounce level, some short
    function automatic void pick_run(inout logic lvl, output int len);
        int db;
        db  = int'(sb.db_level);
        lvl = ~lvl;
        if ($urandom_range(0, 99) < 20) len = $urandom_range(1, 3);
        else len = $urandom_range(db + 1, db + 8);
    endfunction

    task automatic send_reading(logic up_lvl, logic dn_lvl, logic [31:0] now, logic reading,
                                logic signed [14:0] temp, int gap);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, temp, now, dn_lvl, up_lvl};
        s_tuser  <= reading;
        do @(posedge aclk); while (!s_tready);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
    endtask

    task automatic program_regs(int h, int b, int lo, int hi, int db, int iv);
        put_reg(hts_pkg::CFG_HYSTERESIS, h);
        put_reg(hts_pkg::CFG_HEATER_BAND, b);
        put_reg(hts_pkg::CFG_SP_MIN, lo);
        put_reg(hts_pkg::CFG_SP_MAX, hi);
        put_reg(hts_pkg::CFG_DEBOUNCE, db);
        put_reg(hts_pkg::CFG_INTERVAL, iv);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        int   up_left;
        int   dn_left;
        int   burst_left;
        int   gap;
        logic up_lvl;
        logic dn_lvl;
        logic up_bit;
        logic dn_bit;
        up_left    = 0;
        dn_left    = 0;
        burst_left = 0;
        up_lvl     = $urandom_range(0, 1);
        dn_lvl     = $urandom_range(0, 1);
        for (int k = 0; k < count; k++) begin
            if (up_left == 0) pick_run(up_lvl, up_left);
            if (dn_left == 0) pick_run(dn_lvl, dn_left);
            up_left--;
            dn_left--;
            up_bit = up_lvl ^ ($urandom_range(0, 99) < 4);
            dn_bit = dn_lvl ^ ($urandom_range(0, 99) < 4);
            ms_now = next_ms(ms_now);
            // receiver holds off while beats keep coming back to back
            if (k == count / 3) begin
                long_stall_req = 1'b1;
                burst_left     = 30;
            end
            gap = (burst_left > 0) ? 0 : pick_gap();
            if (burst_left > 0) burst_left--;
            send_reading(up_bit, dn_bit, ms_now, $urandom_range(0, 99) < 85, pick_temp(), gap);
            if (burst_left == 0 && $urandom_range(0, 99) < 3) drain();
        end
    endtask

    task automatic run_phase(int h, int b, int lo, int hi, int db, int iv, int count,
                             logic quiet);
        drain();
        program_regs(h, b, lo, hi, db, iv);
        steady = quiet;
        run_random(count);
        steady = 1'b0;
    endtask

    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        aresetn        = 1'b0;
        steady         = 1'b0;
        long_stall_req = 1'b0;
        ms_now         = '0;
        sb             = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // relay bands at the reset settings: setpoint 60, band 200, heater band 200
        send_reading(1'b1, 1'b1, 32'd0,  1'b0, -15'sd4500, 0);
        send_reading(1'b1, 1'b1, 32'd10, 1'b1, 15'sd13000, 0);
        send_reading(1'b1, 1'b1, 32'd20, 1'b1, -15'sd4500, 1);
        send_reading(1'b1, 1'b1, 32'd30, 1'b1, 15'sd5700, 0);
        send_reading(1'b1, 1'b1, 32'd40, 1'b1, 15'sd6000, 2);
        send_reading(1'b1, 1'b1, 32'd50, 1'b1, 15'sd5700, 0);
        send_reading(1'b1, 1'b1, 32'd60, 1'b1, 15'sd6201, 0);
        send_reading(1'b1, 1'b1, 32'd70, 1'b1, 15'sd6200, 0);
        send_reading(1'b1, 1'b1, 32'd80, 1'b1, 15'sd5800, 0);
        send_reading(1'b1, 1'b1, 32'd90, 1'b1, 15'sd5599, 0);

        // keys with a one-beat debounce and a narrow setpoint window
        drain();
        program_regs(100, 50, 59, 61, 1, 300);
        send_reading(1'b0, 1'b1, 32'd1000, 1'b1, 15'sd6100, 0);
        send_reading(1'b1, 1'b1, 32'd1100, 1'b0, 15'sd0, 0);
        send_reading(1'b0, 1'b1, 32'd1200, 1'b1, 15'sd6100, 0);
        send_reading(1'b1, 1'b1, 32'd1400, 1'b0, 15'sd0, 1);
        send_reading(1'b0, 1'b1, 32'd1600, 1'b0, 15'sd0, 0);
        send_reading(1'b1, 1'b0, 32'd1700, 1'b1, 15'sd5000, 0);
        send_reading(1'b1, 1'b1, 32'd1800, 1'b0, 15'sd0, 0);
        send_reading(1'b1, 1'b0, 32'd1900, 1'b0, 15'sd0, 0);
        send_reading(1'b0, 1'b0, 32'd2400, 1'b1, 15'sd5900, 0);
        send_reading(1'b1, 1'b1, 32'd2500, 1'b1, 15'sd6200, 0);
        ms_now = 32'd2500;

        run_phase(200, 200, 20, 75, 10, 300, 50, 1'b0);
        run_phase(0, 0, 0, 100, 1, 0, 55, 1'b1);
        ms_now = 32'hFFFF_F000;
        run_phase(2000, 2000, 0, 100, 15, 65535, 60, 1'b0);
        // inverted limits
        run_phase(50, 1000, 70, 30, 3, 100, 55, 1'b0);
        // zero debounce level, time close to the wrap
        ms_now = 32'hFFFF_FF00;
        run_phase(150, 300, 55, 65, 0, 50, 55, 1'b0);
        run_phase(1, 2000, 60, 60, 2, 20, 45, 1'b0);
        run_phase($urandom_range(0, 2000), $urandom_range(0, 2000), $urandom_range(0, 100),
                  $urandom_range(0, 100), $urandom_range(1, 15), $urandom_range(0, 1000),
                  60, 1'b0);
        run_phase($urandom_range(0, 2000), $urandom_range(0, 2000), $urandom_range(0, 100),
                  $urandom_range(0, 100), $urandom_range(1, 15), $urandom_range(0, 1000),
                  60, 1'b0);

        drain();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0) sb.mismatches++;
        if (sb.mismatches == 0) begin
            $display("hysteresis_thermostat_with_setpoint_keys: match");
        end else begin
            $display("hysteresis_thermostat_with_setpoint_keys: mismatch");
        end
        $finish;
    end
endmodule
